### design/rgb_pixel_color_converter_defines.svh
// Assertion macros shared by the checker of the RGB pixel color converter.
`ifndef RGB_PIXEL_COLOR_CONVERTER_DEFINES_SVH
`define RGB_PIXEL_COLOR_CONVERTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpcc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RPCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpcc: next-cycle check failed");

`endif

### design/rpcc_pkg.sv
// Package with types, stage numbering and constants of the RGB pixel color converter.
`timescale 1ns / 1ps
`default_nettype none

package rpcc_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned SUM_W    = 18;
    localparam int unsigned PROD_W   = 26;
    localparam int unsigned ACC_W    = 27;
    localparam int unsigned NUM_W    = 34;
    localparam int unsigned DIV_W    = 18;
    localparam int unsigned Y_W      = 24;
    localparam int unsigned QE_W     = 17;
    localparam int unsigned RECIP_W  = 25;
    localparam int unsigned COEF_W   = 10;

    // Pipeline stage numbering.
    localparam int unsigned NUM_STAGES = 13;
    localparam int unsigned ST_IN      = 0;
    localparam int unsigned ST_SUM     = 1;
    localparam int unsigned ST_ACC     = 2;
    localparam int unsigned ST_PREP    = 3;
    localparam int unsigned ST_RECIP   = 4;
    localparam int unsigned ST_MULQ    = 5;
    localparam int unsigned ST_SEPIA   = 6;
    localparam int unsigned ST_ALIGN   = 11;
    localparam int unsigned ST_OUT     = 12;

    // Grayscale divider: two quotient bits per stage.
    localparam int unsigned DIV_STAGES   = 8;
    localparam int unsigned BITS_PER_DIV = 2;
    localparam int unsigned QUOT_W       = 16;

    // Sepia rounding: floor((v + 500) / 1000) = floor(((v + 500) >> 3) / 125).
    localparam int unsigned SEPIA_SCALE  = 1000;
    localparam int unsigned ROUND_BIAS   = 500;
    localparam int unsigned SEPIA_DIV    = 125;
    localparam int unsigned RECIP_SHIFT  = 31;
    localparam logic [RECIP_W-1:0] RECIP_M = 25'd17179869;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef logic [COEF_W-1:0] t_coef;

    localparam t_coef SEPIA_COEF [3][3] = '{
        '{10'd393, 10'd769, 10'd189},
        '{10'd349, 10'd686, 10'd168},
        '{10'd272, 10'd534, 10'd131}
    };

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    typedef enum logic [1:0] {
        MODE_BITMAP  = 2'd0,
        MODE_GRAY    = 2'd1,
        MODE_ISOLATE = 2'd2,
        MODE_SEPIA   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MODE      = 2'd0,
        CFG_MAX_VALUE = 2'd1,
        CFG_MAX_GRAY  = 2'd2,
        CFG_CHANNEL   = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_mode               mode;
        logic [SAMPLE_W-1:0] max_value;
        logic [SAMPLE_W-1:0] gray_limit;
        logic [1:0]          channel_select;
    } t_cfg;

endpackage

`default_nettype wire

### design/rpcc_in_if.sv
// Input pixel channel: valid/ready handshake with the three color samples.
`timescale 1ns / 1ps
`default_nettype none

interface rpcc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

`default_nettype wire

### design/rpcc_out_if.sv
// Output pixel channel: valid/ready handshake with the converted pixel.
`timescale 1ns / 1ps
`default_nettype none

interface rpcc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] level_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output level_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input level_out, output ready);
endinterface

`default_nettype wire

### design/rpcc_sepia.sv
// Sepia datapath: fixed-point 3x3 matrix, round half up by reciprocal, clamp, align.
`timescale 1ns / 1ps
`default_nettype none

module rpcc_sepia (
    input  logic                 i_clk,
    input  rpcc_pkg::t_stage_en  i_en,
    input  rpcc_pkg::t_cfg       i_cfg,
    input  logic [15:0]          i_red,
    input  logic [15:0]          i_green,
    input  logic [15:0]          i_blue,
    output logic [15:0]          o_red,
    output logic [15:0]          o_green,
    output logic [15:0]          o_blue
);

    localparam int unsigned MUL_W = rpcc_pkg::Y_W + rpcc_pkg::RECIP_W;

    logic [rpcc_pkg::SAMPLE_W-1:0] px [3];

    logic [rpcc_pkg::PROD_W-1:0] r_prod [3][3];
    logic [rpcc_pkg::ACC_W-1:0]  r_acc  [3];
    logic [rpcc_pkg::Y_W-1:0]    r_y3   [3];
    logic                        r_clip3 [3];
    logic [rpcc_pkg::Y_W-1:0]    r_y4   [3];
    logic                        r_clip4 [3];
    logic [rpcc_pkg::QE_W-1:0]   r_qe4  [3];
    logic [rpcc_pkg::Y_W-1:0]    r_y5   [3];
    logic                        r_clip5 [3];
    logic [rpcc_pkg::QE_W-1:0]   r_qe5  [3];
    logic [rpcc_pkg::Y_W-1:0]    r_qm5  [3];
    logic [15:0]                 r_dly  [rpcc_pkg::ST_SEPIA:rpcc_pkg::ST_ALIGN][3];

    logic [rpcc_pkg::PROD_W-1:0] n_prod [3][3];
    logic [rpcc_pkg::ACC_W-1:0]  n_acc  [3];
    logic [rpcc_pkg::Y_W-1:0]    n_y    [3];
    logic                        n_clip [3];
    logic [rpcc_pkg::QE_W-1:0]   n_qe   [3];
    logic [rpcc_pkg::Y_W-1:0]    n_qm   [3];
    logic [15:0]                 n_res  [3];
    logic [rpcc_pkg::ACC_W-1:0]  limit;

    assign px[0] = i_red;
    assign px[1] = i_green;
    assign px[2] = i_blue;

    // Clamp threshold in thousandths: 1000 * max_value.
    assign limit = rpcc_pkg::ACC_W'(i_cfg.max_value)
                 * rpcc_pkg::ACC_W'(rpcc_pkg::SEPIA_SCALE);

    always_comb begin
        logic [rpcc_pkg::ACC_W-1:0] rounded;
        logic [MUL_W-1:0]           mul;
        logic [rpcc_pkg::Y_W-1:0]   rem;
        logic [rpcc_pkg::QE_W-1:0]  quot;
        rounded = '0;
        mul     = '0;
        rem     = '0;
        quot    = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = rpcc_pkg::PROD_W'(rpcc_pkg::SEPIA_COEF[r][c])
                             * rpcc_pkg::PROD_W'(px[c]);
            end
            n_acc[r] = rpcc_pkg::ACC_W'(r_prod[r][0]) + rpcc_pkg::ACC_W'(r_prod[r][1])
                     + rpcc_pkg::ACC_W'(r_prod[r][2]);

            rounded   = r_acc[r] + rpcc_pkg::ACC_W'(rpcc_pkg::ROUND_BIAS);
            n_y[r]    = rounded[rpcc_pkg::ACC_W-1:3];
            n_clip[r] = (r_acc[r] > limit);

            // Quotient estimate by 125 is exact or one short.
            mul      = MUL_W'(r_y3[r]) * MUL_W'(rpcc_pkg::RECIP_M);
            n_qe[r]  = mul[rpcc_pkg::RECIP_SHIFT +: rpcc_pkg::QE_W];

            n_qm[r]  = rpcc_pkg::Y_W'(r_qe4[r]) * rpcc_pkg::Y_W'(rpcc_pkg::SEPIA_DIV);

            rem  = r_y5[r] - r_qm5[r];
            quot = r_qe5[r] + rpcc_pkg::QE_W'(rem >= rpcc_pkg::Y_W'(rpcc_pkg::SEPIA_DIV));
            n_res[r] = r_clip5[r] ? i_cfg.max_value : quot[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            if (i_en[rpcc_pkg::ST_SUM]) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= n_prod[r][c];
                end
            end
            if (i_en[rpcc_pkg::ST_ACC]) begin
                r_acc[r] <= n_acc[r];
            end
            if (i_en[rpcc_pkg::ST_PREP]) begin
                r_y3[r]    <= n_y[r];
                r_clip3[r] <= n_clip[r];
            end
            if (i_en[rpcc_pkg::ST_RECIP]) begin
                r_y4[r]    <= r_y3[r];
                r_clip4[r] <= r_clip3[r];
                r_qe4[r]   <= n_qe[r];
            end
            if (i_en[rpcc_pkg::ST_MULQ]) begin
                r_y5[r]    <= r_y4[r];
                r_clip5[r] <= r_clip4[r];
                r_qe5[r]   <= r_qe4[r];
                r_qm5[r]   <= n_qm[r];
            end
            if (i_en[rpcc_pkg::ST_SEPIA]) begin
                r_dly[rpcc_pkg::ST_SEPIA][r] <= n_res[r];
            end
            for (int s = rpcc_pkg::ST_SEPIA + 1; s <= rpcc_pkg::ST_ALIGN; s++) begin
                if (i_en[s]) begin
                    r_dly[s][r] <= r_dly[s-1][r];
                end
            end
        end
    end

    assign o_red   = r_dly[rpcc_pkg::ST_ALIGN][0];
    assign o_green = r_dly[rpcc_pkg::ST_ALIGN][1];
    assign o_blue  = r_dly[rpcc_pkg::ST_ALIGN][2];

endmodule

`default_nettype wire

### design/rpcc_gray.sv
// Grayscale datapath: sum * gray_limit over 3 * max_value in a pipelined radix-4 divider.
`timescale 1ns / 1ps
`default_nettype none

module rpcc_gray (
    input  logic                          i_clk,
    input  rpcc_pkg::t_stage_en           i_en,
    input  rpcc_pkg::t_cfg                i_cfg,
    input  logic [rpcc_pkg::SUM_W-1:0]    i_sum,
    output logic [rpcc_pkg::QUOT_W-1:0]   o_quot,
    output logic                          o_ovf
);

    localparam int unsigned ND = rpcc_pkg::DIV_STAGES;
    localparam int unsigned QW = rpcc_pkg::QUOT_W;
    localparam int unsigned DW = rpcc_pkg::DIV_W;

    logic [rpcc_pkg::NUM_W-1:0] r_num;
    logic [rpcc_pkg::NUM_W-1:0] n_num;

    // Index 0 is the setup stage, 1..ND the divider stages.
    logic [DW-1:0] r_rem [ND+1];
    logic [QW-1:0] r_low [ND+1];
    logic [QW-1:0] r_q   [ND+1];
    logic [DW-1:0] r_dv  [ND+1];
    logic          r_ov  [ND+1];

    logic [DW-1:0] n_rem [ND+1];
    logic [QW-1:0] n_low [ND+1];
    logic [QW-1:0] n_q   [ND+1];
    logic [DW-1:0] n_dv;
    logic          n_ov;

    assign n_num = rpcc_pkg::NUM_W'(i_sum) * rpcc_pkg::NUM_W'(i_cfg.gray_limit);
    assign n_dv  = DW'({i_cfg.max_value, 1'b0}) + DW'(i_cfg.max_value);

    // A quotient of 2^16 or more always clamps. A zero divisor lands here as well.
    assign n_ov  = (r_num >= (rpcc_pkg::NUM_W'(n_dv) << QW));

    always_comb begin
        logic [DW:0] trial;
        trial    = '0;
        n_rem[0] = r_num[rpcc_pkg::NUM_W-1:QW];
        n_low[0] = r_num[QW-1:0];
        n_q[0]   = '0;
        for (int j = 1; j <= ND; j++) begin
            n_rem[j] = r_rem[j-1];
            n_low[j] = r_low[j-1];
            n_q[j]   = r_q[j-1];
            for (int b = 0; b < rpcc_pkg::BITS_PER_DIV; b++) begin
                trial    = {n_rem[j], n_low[j][QW-1]};
                n_low[j] = {n_low[j][QW-2:0], 1'b0};
                if (trial >= {1'b0, r_dv[j-1]}) begin
                    n_rem[j] = DW'(trial - {1'b0, r_dv[j-1]});
                    n_q[j]   = {n_q[j][QW-2:0], 1'b1};
                end else begin
                    n_rem[j] = trial[DW-1:0];
                    n_q[j]   = {n_q[j][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[rpcc_pkg::ST_ACC]) begin
            r_num <= n_num;
        end
        if (i_en[rpcc_pkg::ST_PREP]) begin
            r_rem[0] <= n_rem[0];
            r_low[0] <= n_low[0];
            r_q[0]   <= n_q[0];
            r_dv[0]  <= n_dv;
            r_ov[0]  <= n_ov;
        end
        for (int j = 1; j <= ND; j++) begin
            if (i_en[rpcc_pkg::ST_PREP + j]) begin
                r_rem[j] <= n_rem[j];
                r_low[j] <= n_low[j];
                r_q[j]   <= n_q[j];
                r_dv[j]  <= r_dv[j-1];
                r_ov[j]  <= r_ov[j-1];
            end
        end
    end

    assign o_quot = r_q[ND];
    assign o_ovf  = r_ov[ND];

endmodule

`default_nettype wire

### design/rgb_pixel_color_converter.sv
// Top level of the RGB pixel color converter: config registers, pipeline control, output.
`timescale 1ns / 1ps
`default_nettype none

// The converter takes one RGB pixel per clock and gives one converted pixel per clock
// while the output side takes them; results are offered in the order the pixels arrived.
// The pipeline depth is set by the grayscale path, whose division by 3 * max_value runs
// through eight divider stages of two quotient bits each; every mode goes through the same
// 13 stages. When the output side stalls, the pipeline keeps filling its empty stages, so
// input transfers continue until every stage holds a pixel. Configuration registers are
// written through a plain write port and must only be changed while no pixel is in flight.
module rgb_pixel_color_converter #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    rpcc_in_if.sink           i_pix,
    rpcc_out_if.source        o_pix
);

    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] level;
    } t_result;

    rpcc_pkg::t_cfg      r_cfg;
    rpcc_pkg::t_stage_en r_vld;
    rpcc_pkg::t_stage_en en;

    logic [15:0] r_red0;
    logic [15:0] r_green0;
    logic [15:0] r_blue0;

    logic [rpcc_pkg::SUM_W-1:0] r_sum;
    logic [rpcc_pkg::SUM_W-1:0] n_sum;
    logic [rpcc_pkg::SUM_W-1:0] thr;
    logic [15:0]                half;

    t_result r_smp [rpcc_pkg::ST_SUM:rpcc_pkg::ST_ALIGN];
    t_result n_smp;
    t_result r_out;
    t_result n_out;

    logic [15:0]                  sep_red;
    logic [15:0]                  sep_green;
    logic [15:0]                  sep_blue;
    logic [rpcc_pkg::QUOT_W-1:0]  gray_q;
    logic                         gray_ovf;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= rpcc_pkg::MODE_BITMAP;
            r_cfg.max_value      <= 16'd255;
            r_cfg.gray_limit     <= 16'd255;
            r_cfg.channel_select <= rpcc_pkg::CH_RED;
        end else if (i_cfg_we) begin
            unique case (rpcc_pkg::t_cfg_index'(i_cfg_index))
                rpcc_pkg::CFG_MODE: begin
                    r_cfg.mode <= rpcc_pkg::t_mode'(i_cfg_data[1:0]);
                end
                rpcc_pkg::CFG_MAX_VALUE: begin
                    r_cfg.max_value <= i_cfg_data;
                end
                rpcc_pkg::CFG_MAX_GRAY: begin
                    r_cfg.gray_limit <= i_cfg_data;
                end
                rpcc_pkg::CFG_CHANNEL: begin
                    r_cfg.channel_select <= i_cfg_data[1:0];
                end
            endcase
        end
    end

    // A stage advances when it or any stage after it is empty, or the output is taken.
    always_comb begin
        for (int s = 0; s < rpcc_pkg::NUM_STAGES; s++) begin
            en[s] = o_pix.ready
                 || !(&(r_vld | rpcc_pkg::t_stage_en'((rpcc_pkg::t_stage_en'(1) << s)
                                                     - rpcc_pkg::t_stage_en'(1))));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[rpcc_pkg::ST_IN]) begin
                r_vld[rpcc_pkg::ST_IN] <= i_pix.valid;
            end
            for (int s = 1; s < rpcc_pkg::NUM_STAGES; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign i_pix.ready = en[rpcc_pkg::ST_IN];

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (en[rpcc_pkg::ST_IN]) begin
            r_red0   <= i_pix.red_in & SAMPLE_MASK;
            r_green0 <= i_pix.green_in & SAMPLE_MASK;
            r_blue0  <= i_pix.blue_in & SAMPLE_MASK;
        end
    end

    // floor(sum / 3) < floor(max_value / 2) holds exactly when sum < 3 * floor(max_value / 2).
    assign n_sum = rpcc_pkg::SUM_W'(r_red0) + rpcc_pkg::SUM_W'(r_green0)
                 + rpcc_pkg::SUM_W'(r_blue0);
    assign half  = r_cfg.max_value >> 1;
    assign thr   = rpcc_pkg::SUM_W'(half) + rpcc_pkg::SUM_W'({half, 1'b0});

    always_comb begin
        n_smp = '0;
        case (r_cfg.mode)
            rpcc_pkg::MODE_BITMAP: begin
                n_smp.level = 16'(n_sum >= thr);
            end
            rpcc_pkg::MODE_ISOLATE: begin
                n_smp.red   = (r_cfg.channel_select == rpcc_pkg::CH_RED)   ? r_red0   : '0;
                n_smp.green = (r_cfg.channel_select == rpcc_pkg::CH_GREEN) ? r_green0 : '0;
                n_smp.blue  = (r_cfg.channel_select == rpcc_pkg::CH_BLUE)  ? r_blue0  : '0;
            end
            default: begin
                n_smp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[rpcc_pkg::ST_SUM]) begin
            r_sum                  <= n_sum;
            r_smp[rpcc_pkg::ST_SUM] <= n_smp;
        end
        for (int s = rpcc_pkg::ST_SUM + 1; s <= rpcc_pkg::ST_ALIGN; s++) begin
            if (en[s]) begin
                r_smp[s] <= r_smp[s-1];
            end
        end
    end

    rpcc_sepia u_sepia (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_red   (r_red0),
        .i_green (r_green0),
        .i_blue  (r_blue0),
        .o_red   (sep_red),
        .o_green (sep_green),
        .o_blue  (sep_blue)
    );

    rpcc_gray u_gray (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cfg  (r_cfg),
        .i_sum  (r_sum),
        .o_quot (gray_q),
        .o_ovf  (gray_ovf)
    );

    // Output stage: select the result of the active mode.
    always_comb begin
        n_out = r_smp[rpcc_pkg::ST_ALIGN];
        case (r_cfg.mode)
            rpcc_pkg::MODE_GRAY: begin
                n_out       = '0;
                n_out.level = (gray_ovf || (gray_q > r_cfg.gray_limit)) ? r_cfg.gray_limit
                                                                        : gray_q;
            end
            rpcc_pkg::MODE_SEPIA: begin
                n_out.red   = sep_red;
                n_out.green = sep_green;
                n_out.blue  = sep_blue;
                n_out.level = '0;
            end
            default: begin
                n_out = r_smp[rpcc_pkg::ST_ALIGN];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[rpcc_pkg::ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_pix.valid     = r_vld[rpcc_pkg::ST_OUT];
    assign o_pix.red_out   = r_out.red;
    assign o_pix.green_out = r_out.green;
    assign o_pix.blue_out  = r_out.blue;
    assign o_pix.level_out = r_out.level;

endmodule

`default_nettype wire

### design/rpcc_checker.sv
// Port-level checks of the RGB pixel color converter and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_pixel_color_converter_defines.svh"

module rpcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_red,
    input logic [15:0] i_green,
    input logic [15:0] i_blue,
    input logic [15:0] i_level
);

    // A stalled result stays offered and unchanged.
    `RPCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue) && $stable(i_level))

    // A nonzero level only comes from bitmap or grayscale, where the colors are zero.
    `RPCC_ASSERT_NOW(a_level_excl, i_clk, i_rst_n, i_out_valid && (i_level != 16'd0), (i_red == 16'd0) && (i_green == 16'd0) && (i_blue == 16'd0))

    // With the output stage empty, every stage can move, so an input transfer is possible.
    `RPCC_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !i_out_valid || i_out_ready, i_in_ready)

    // Nothing is offered in the first cycle after reset is released.
    `RPCC_ASSERT_NOW(a_empty_rst, i_clk, i_rst_n, $rose(i_rst_n), !i_out_valid)

endmodule

bind rgb_pixel_color_converter rpcc_checker u_rpcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red_out),
    .i_green     (o_pix.green_out),
    .i_blue      (o_pix.blue_out),
    .i_level     (o_pix.level_out)
);

`default_nettype wire
